>>> rtl/blg_pkg.sv
// ---------------------------------------------------------------------------
// blg_pkg
// Types and constants shared by the battery level gauge modules: word
// layouts, controller states, command and status groups, fixed widths.
// ---------------------------------------------------------------------------
package blg_pkg;

    // fixed field widths
    localparam int SAMPLE_W  = 12;
    localparam int STATUS_W  = 8;
    localparam int MV_W      = 13;
    localparam int REF_W     = 12;
    localparam int LEVEL_W   = 7;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;

    // shared divider: dividend and divisor widths, two quotient bits a cycle
    localparam int DIVD_W    = 24;
    localparam int DVS_W     = 16;
    localparam int DIV_STEPS = DIVD_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // status bit tested in both charger bytes
    localparam int STATUS_BIT_POS = 3;

    // percent scale and forced full level
    localparam logic [LEVEL_W-1:0] PERCENT_FULL = 7'd100;
    localparam int                 PERCENT_SCALE = 100;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_MV   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_MV    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ADC_REF_MV = 2'd2;

    // register reset values
    localparam logic [MV_W-1:0]  EMPTY_MV_RST   = 13'd3300;
    localparam logic [MV_W-1:0]  FULL_MV_RST    = 13'd3900;
    localparam logic [REF_W-1:0] ADC_REF_MV_RST = 12'd3300;

    // history reset value of the newest entry
    localparam logic [SAMPLE_W-1:0] HIST_HEAD_RST = 12'd4095;

    // input word
    typedef struct packed {
        logic [SAMPLE_W-1:0] adc_sample;
        logic [STATUS_W-1:0] charge_status_byte;
        logic [STATUS_W-1:0] battery_status_byte;
    } blg_in_t;

    // result word
    typedef struct packed {
        logic [MV_W-1:0]    voltage_mv;
        logic [LEVEL_W-1:0] level_percent;
        logic               is_charging;
    } blg_out_t;

    // operand selection for the shared divider
    typedef enum logic [1:0] {
        DIV_AVG,
        DIV_VOLT,
        DIV_LVL
    } blg_div_sel_t;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_ACCUM,
        S_AVG_START,
        S_AVG_WAIT,
        S_MUL,
        S_VOLT_START,
        S_VOLT_WAIT,
        S_CLAMP,
        S_LVL_START,
        S_LVL_WAIT,
        S_FINISH
    } blg_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic         load;
        logic         accum;
        logic         shift;
        logic         div_start;
        blg_div_sel_t div_sel;
        logic         mul;
        logic         clamp;
        logic         finish;
    } blg_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic div_busy;
        logic out_free;
    } blg_stat_t;

endpackage

>>> rtl/blg_divider.sv
// ---------------------------------------------------------------------------
// blg_divider
// Restoring unsigned divider, two quotient bits per cycle. Shared by the
// average, scaling and percent steps of the gauge.
// ---------------------------------------------------------------------------
module blg_divider
    import blg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [DVS_W-1:0]  divisor,
    output logic              busy,
    output logic [DIVD_W-1:0] quotient
);

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W:0]       rem_reg, rem_next;
    logic [DIVD_W-1:0]    quo_reg, quo_next;
    logic [DVS_W-1:0]     dvs_reg, dvs_next;

    logic [DVS_W:0]       rem_a, rem_b;
    logic [DIVD_W-1:0]    quo_a, quo_b;

    // two dependent shift and subtract steps
    always_comb
    begin
        rem_a = {rem_reg[DVS_W-1:0], quo_reg[DIVD_W-1]};
        quo_a = {quo_reg[DIVD_W-2:0], 1'b0};
        if (rem_a >= {1'b0, dvs_reg})
        begin
            rem_a    = rem_a - {1'b0, dvs_reg};
            quo_a[0] = 1'b1;
        end
        rem_b = {rem_a[DVS_W-1:0], quo_a[DIVD_W-1]};
        quo_b = {quo_a[DIVD_W-2:0], 1'b0};
        if (rem_b >= {1'b0, dvs_reg})
        begin
            rem_b    = rem_b - {1'b0, dvs_reg};
            quo_b[0] = 1'b1;
        end
    end

    // next values
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = rem_b;
            quo_next = quo_b;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operand registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/blg_ctrl.sv
// ---------------------------------------------------------------------------
// blg_ctrl
// Sequencer of the gauge: accumulates the history, runs the three divides
// and the multiply in turn, and hands the result to the output register.
// ---------------------------------------------------------------------------
module blg_ctrl
    import blg_pkg::*;
#(
    parameter int HIST_DEPTH = 9
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  blg_stat_t stat,
    output blg_cmd_t  cmd
);

    localparam int CNT_W = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

    blg_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             accum_last;

    assign accum_last = (cnt_reg == CNT_W'(HIST_DEPTH - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:       if (in_valid) state_next = S_ACCUM;
            S_ACCUM:      if (accum_last) state_next = S_AVG_START;
            S_AVG_START:  state_next = S_AVG_WAIT;
            S_AVG_WAIT:   if (!stat.div_busy) state_next = S_MUL;
            S_MUL:        state_next = S_VOLT_START;
            S_VOLT_START: state_next = S_VOLT_WAIT;
            S_VOLT_WAIT:  if (!stat.div_busy) state_next = S_CLAMP;
            S_CLAMP:      state_next = S_LVL_START;
            S_LVL_START:  state_next = S_LVL_WAIT;
            S_LVL_WAIT:   if (!stat.div_busy) state_next = S_FINISH;
            S_FINISH:     if (stat.out_free) state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        cmd.div_sel = DIV_AVG;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_ACCUM:      cmd.accum = 1'b1;
            S_AVG_START:
            begin
                cmd.shift     = 1'b1;
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_AVG;
            end
            S_MUL:        cmd.mul = 1'b1;
            S_VOLT_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_VOLT;
            end
            S_CLAMP:      cmd.clamp = 1'b1;
            S_LVL_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_LVL;
            end
            S_FINISH:     cmd.finish = stat.out_free;
            default:      cmd.finish = 1'b0;
        endcase
    end

    // accumulate counter
    always_comb
    begin
        cnt_next = cnt_reg;
        if (state_reg == S_IDLE)
        begin
            cnt_next = '0;
        end
        else if (state_reg == S_ACCUM)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

>>> rtl/blg_datapath.sv
// ---------------------------------------------------------------------------
// blg_datapath
// Sample history ring, running sum, multiplier, clamp, shared divider,
// configuration registers and the output register of the gauge.
// ---------------------------------------------------------------------------
module blg_datapath
    import blg_pkg::*;
#(
    parameter int WINDOW_LEN    = 10,
    parameter int ADC_FULL_CODE = 4095
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  blg_cmd_t             cmd,
    output blg_stat_t            stat,
    input  blg_in_t              in_word,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output blg_out_t             out_word
);

    localparam int HIST_DEPTH = WINDOW_LEN - 1;
    localparam int SUM_W      = SAMPLE_W + $clog2(WINDOW_LEN);
    localparam int PROD_W     = SAMPLE_W + REF_W;
    localparam int VOLT_W     = DIVD_W + 1;

    // configuration
    logic [MV_W-1:0]  empty_mv_reg, empty_mv_next;
    logic [MV_W-1:0]  full_mv_reg, full_mv_next;
    logic [REF_W-1:0] adc_ref_reg, adc_ref_next;

    // item working registers
    logic [SAMPLE_W-1:0] hist_reg [HIST_DEPTH];
    logic [SAMPLE_W-1:0] hist_next [HIST_DEPTH];
    logic [SAMPLE_W-1:0] sample_reg, sample_next;
    logic                chg_reg, chg_next;
    logic                bat_full_reg, bat_full_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [MV_W-1:0]     volt_reg, volt_next;

    // output register
    logic     out_valid_reg, out_valid_next;
    blg_out_t out_word_reg, out_word_next;

    // divider hookup
    logic [DIVD_W-1:0] div_dividend;
    logic [DVS_W-1:0]  div_divisor;
    logic              div_busy;
    logic [DIVD_W-1:0] div_quot;

    logic [MV_W-1:0]   lvl_diff;
    logic [MV_W-1:0]   lvl_span;
    logic [DIVD_W-1:0] lvl_num;
    logic [VOLT_W-1:0] volt_wide;
    logic [VOLT_W-1:0] volt_clamped;
    logic              window_ok;

    // configuration writes
    always_comb
    begin
        empty_mv_next = empty_mv_reg;
        full_mv_next  = full_mv_reg;
        adc_ref_next  = adc_ref_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_EMPTY_MV:   empty_mv_next = cfg_data;
                REG_FULL_MV:    full_mv_next  = cfg_data;
                REG_ADC_REF_MV: adc_ref_next  = cfg_data[REF_W-1:0];
                default:        adc_ref_next  = adc_ref_reg;
            endcase
        end
    end

    // history ring and running sum: rotate while summing, then shift in
    always_comb
    begin
        hist_next     = hist_reg;
        sample_next   = sample_reg;
        chg_next      = chg_reg;
        bat_full_next = bat_full_reg;
        sum_next      = sum_reg;
        if (cmd.load)
        begin
            sample_next   = in_word.adc_sample;
            chg_next      = in_word.charge_status_byte[STATUS_BIT_POS];
            bat_full_next = in_word.battery_status_byte[STATUS_BIT_POS];
            sum_next      = SUM_W'(in_word.adc_sample);
        end
        if (cmd.accum)
        begin
            sum_next     = sum_reg + SUM_W'(hist_reg[HIST_DEPTH-1]);
            hist_next[0] = hist_reg[HIST_DEPTH-1];
            for (int i = 1; i < HIST_DEPTH; i++)
            begin
                hist_next[i] = hist_reg[i-1];
            end
        end
        if (cmd.shift)
        begin
            hist_next[0] = sample_reg;
            for (int i = 1; i < HIST_DEPTH; i++)
            begin
                hist_next[i] = hist_reg[i-1];
            end
        end
    end

    // scale the average against the reference
    assign prod_next = cmd.mul ? PROD_W'(div_quot[SAMPLE_W-1:0]) * PROD_W'(adc_ref_reg)
                               : prod_reg;

    // double and clamp to the window, lower bound first
    always_comb
    begin
        volt_wide    = {div_quot, 1'b0};
        volt_clamped = volt_wide;
        if (volt_clamped < VOLT_W'(empty_mv_reg))
        begin
            volt_clamped = VOLT_W'(empty_mv_reg);
        end
        if (volt_clamped > VOLT_W'(full_mv_reg))
        begin
            volt_clamped = VOLT_W'(full_mv_reg);
        end
        volt_next = cmd.clamp ? volt_clamped[MV_W-1:0] : volt_reg;
    end

    // percent numerator and span
    assign lvl_diff  = volt_reg - empty_mv_reg;
    assign lvl_span  = full_mv_reg - empty_mv_reg;
    assign lvl_num   = DIVD_W'(DIVD_W'(lvl_diff) * DIVD_W'(PERCENT_SCALE));
    assign window_ok = (full_mv_reg > empty_mv_reg);

    // divider operand selection
    always_comb
    begin
        unique case (cmd.div_sel)
            DIV_AVG:
            begin
                div_dividend = DIVD_W'(sum_reg);
                div_divisor  = DVS_W'(WINDOW_LEN);
            end
            DIV_VOLT:
            begin
                div_dividend = DIVD_W'(prod_reg);
                div_divisor  = DVS_W'(ADC_FULL_CODE);
            end
            DIV_LVL:
            begin
                div_dividend = lvl_num;
                div_divisor  = DVS_W'(lvl_span);
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = '0;
            end
        endcase
    end

    blg_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg & out_stall;
        out_word_next  = out_word_reg;
        if (cmd.finish)
        begin
            out_valid_next           = 1'b1;
            out_word_next.voltage_mv = volt_reg;
            out_word_next.is_charging = chg_reg;
            if (bat_full_reg)
            begin
                out_word_next.level_percent = PERCENT_FULL;
            end
            else if (window_ok)
            begin
                out_word_next.level_percent = div_quot[LEVEL_W-1:0];
            end
            else
            begin
                out_word_next.level_percent = '0;
            end
        end
    end

    assign stat.div_busy = div_busy;
    assign stat.out_free = !out_valid_reg || !out_stall;

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_mv_reg  <= EMPTY_MV_RST;
            full_mv_reg   <= FULL_MV_RST;
            adc_ref_reg   <= ADC_REF_MV_RST;
            out_valid_reg <= 1'b0;
            hist_reg[0]   <= HIST_HEAD_RST;
            for (int i = 1; i < HIST_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else
        begin
            empty_mv_reg  <= empty_mv_next;
            full_mv_reg   <= full_mv_next;
            adc_ref_reg   <= adc_ref_next;
            out_valid_reg <= out_valid_next;
            hist_reg      <= hist_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        chg_reg      <= chg_next;
        bat_full_reg <= bat_full_next;
        sum_reg      <= sum_next;
        prod_reg     <= prod_next;
        volt_reg     <= volt_next;
        out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

>>> rtl/battery_level_gauge.sv
// ---------------------------------------------------------------------------
// battery_level_gauge
// Moving-average battery gauge: averaged voltage, percent level, charge flag.
// ---------------------------------------------------------------------------
// Usage
//   in channel : in_valid / in_stall / in_data, one word per battery sample
//                with both charger status bytes. in_stall is high while an
//                item is being worked on.
//   out channel: out_valid / out_stall / out_data, one result word per input.
//   cfg port   : cfg_we / cfg_index / cfg_data, write only while idle;
//                index 0 empty_mv, 1 full_mv, 2 adc_ref_mv, 3 is ignored.
// Sequence
//   an item is worked on to its end before the next one is accepted. Steps:
//   sum the history ring, average divide, multiply, scaling divide, clamp,
//   percent divide, hand-off; the three divides are passes of the shared
//   two-bit-per-cycle divider.
// Reset
//   registers return to 3300 / 3900 / 3300 mV, history to 4095 then zeros,
//   output empty.
// Stall
//   a finished word waits in the output register; the next item is accepted
//   and worked on meanwhile, and it holds in its last step until the output
//   register is free.
// ---------------------------------------------------------------------------
module battery_level_gauge
    import blg_pkg::*;
#(
    parameter int WINDOW_LEN    = 10,
    parameter int ADC_FULL_CODE = 4095
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  blg_in_t              in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output blg_out_t             out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    blg_cmd_t  cmd;
    blg_stat_t stat;
    logic      in_ready;

    assign in_stall = !in_ready;

    // sequencer
    blg_ctrl #(
        .HIST_DEPTH (WINDOW_LEN - 1)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // arithmetic and storage
    blg_datapath #(
        .WINDOW_LEN    (WINDOW_LEN),
        .ADC_FULL_CODE (ADC_FULL_CODE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_word   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_data)
    );

endmodule
